// ----- hw/rtl/lsi_pkg.sv -----
// ----------------------------------------------------------------------------
// lsi_pkg
// Shared widths, relation codes and the queue item type of the 3D line
// closest-approach intersection block.
// ----------------------------------------------------------------------------
package lsi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TOL_W     = 16;
  localparam int TOL2_W    = 2 * TOL_W;
  localparam int LIM_W     = TOL2_W + 2 * FRAC_BITS;
  localparam int CRD_W     = 32;
  localparam int DW        = CRD_W + 1;          // coordinate differences
  localparam int PW        = 2 * DW;             // products of differences
  localparam int CW        = PW + 1;             // cross product components
  localparam int SQ_W      = 2 * CW;             // c * c and similar terms
  localparam int RCP_W     = DW + CW;            // r * c terms
  localparam int DOT_W     = SQ_W + 2;           // den, tn, sn
  localparam int RC_W      = RCP_W + 2;          // r . c
  localparam int RC2_W     = 2 * RC_W;           // (r . c)^2
  localparam int TD_W      = TOL2_W + DOT_W;     // tol^2 * den
  localparam int NUM_W     = DOT_W + DW;         // tn * d
  localparam int REM_W     = NUM_W + 3;          // rounded dividend
  localparam int DV_W      = DOT_W + 1;          // 2 * den
  localparam int QB        = 34;                 // quotient bits kept
  localparam int V_W       = QB + 2;             // start + quotient
  localparam int IN_W      = 12 * CRD_W;
  localparam int OUT_W     = 104;

  // Wide products are split into 32-bit limbs, one limb product per multiplier.
  localparam int WIDE      = 256;
  localparam int LB        = 32;                 // limb width
  localparam int PP_W      = 2 * (LB + 1);       // signed limb product
  localparam int C_L       = 3;                  // limbs of c, r x e, r x d
  localparam int R_L       = 2;                  // limbs of r and d
  localparam int RC_L      = 4;                  // limbs of r . c
  localparam int DOT_L     = 5;                  // limbs of den and tn
  localparam int TSQ_L     = 2;                  // limbs of tol^2

  typedef logic signed [PP_W-1:0] pp_t;

  typedef enum logic [2:0] {
    REL_PARALLEL = 3'd0,
    REL_SEG_SEG  = 3'd1,
    REL_SEG_LINE = 3'd2,
    REL_LINE     = 3'd3,
    REL_SKEW     = 3'd4
  } rel_t;

  typedef struct packed {
    rel_t                      rel;
    logic [2:0][CRD_W-1:0]     fa;
    logic [2:0][DW-1:0]        d;
    logic [DOT_W-1:0]          tn;
    logic [DOT_W-1:0]          den;
  } item_t;

  localparam int ITEM_W = $bits(item_t);

  // Limb i of an n-limb operand. The lower limbs are unsigned and the top one
  // carries the sign, so each limb product fits a 33 by 33 signed multiplier.
  function automatic logic signed [LB:0] limb(input logic signed [WIDE-1:0] x,
                                               input int i, input int n);
    if (i == n - 1) begin
      return (LB+1)'($signed(x[LB*i +: LB]));
    end
    return {1'b0, x[LB*i +: LB]};
  endfunction

endpackage

// ----- hw/rtl/lsi_front.sv -----
// ----------------------------------------------------------------------------
// lsi_front
// Accepts line pairs and classifies them: cross product, dot products,
// parallel and skew tests, and the in-range tests on t and s.
// ----------------------------------------------------------------------------
module lsi_front
  import lsi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [TOL_W-1:0]  tol,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [IN_W-1:0]   in_data,
  output logic              q_valid,
  input  logic              q_ready,
  output item_t             q_item
);

  logic [9:1] v_r;
  logic       en;

  // Stage 1: differences.
  logic signed [CRD_W-1:0] fa1_r [3];
  logic signed [DW-1:0]    d1_r [3], e1_r [3], r1_r [3];
  logic [TOL_W-1:0]        tol1_r;
  // Stage 2: cross product terms.
  logic signed [PW-1:0]    cp2_r [3], cn2_r [3], ep2_r [3], en2_r [3];
  logic signed [PW-1:0]    dp2_r [3], dn2_r [3];
  logic signed [CRD_W-1:0] fa2_r [3];
  logic signed [DW-1:0]    d2_r [3], r2_r [3];
  logic [TOL_W-1:0]        tol2_r;
  // Stage 3: c, r x e, r x d.
  logic signed [CW-1:0]    c3_r [3], re3_r [3], rd3_r [3];
  logic signed [CRD_W-1:0] fa3_r [3];
  logic signed [DW-1:0]    d3_r [3], r3_r [3];
  logic [TOL_W-1:0]        tol3_r;
  // Stage 4: limb products of the dot product terms.
  pp_t                     cc4_pp_r [3][C_L][C_L];
  pp_t                     tt4_pp_r [3][C_L][C_L];
  pp_t                     ss4_pp_r [3][C_L][C_L];
  pp_t                     rc4_pp_r [3][R_L][C_L];
  logic [TOL2_W-1:0]       tsq4_r;
  logic signed [CRD_W-1:0] fa4_r [3];
  logic signed [DW-1:0]    d4_r [3];
  // Stage 5: dot product terms.
  logic signed [SQ_W-1:0]  cc5_r [3], tt5_r [3], ss5_r [3];
  logic signed [RCP_W-1:0] rcp5_r [3];
  logic [TOL2_W-1:0]       tsq5_r;
  logic signed [CRD_W-1:0] fa5_r [3];
  logic signed [DW-1:0]    d5_r [3];
  // Stage 6: sums.
  logic [DOT_W-1:0]        den6_r;
  logic signed [DOT_W-1:0] tn6_r, sn6_r;
  logic signed [RC_W-1:0]  rc6_r;
  logic [TOL2_W-1:0]       tsq6_r;
  logic signed [CRD_W-1:0] fa6_r [3];
  logic signed [DW-1:0]    d6_r [3];
  // Stage 7: limb products for the skew test.
  pp_t                     rr7_pp_r [RC_L][RC_L];
  pp_t                     td7_pp_r [TSQ_L][DOT_L];
  logic [DOT_W-1:0]        den7_r;
  logic signed [DOT_W-1:0] tn7_r, sn7_r;
  logic [TOL2_W-1:0]       tsq7_r;
  logic signed [CRD_W-1:0] fa7_r [3];
  logic signed [DW-1:0]    d7_r [3];
  // Stage 8: squares for the skew test.
  logic [RC2_W-1:0]        rc2_8_r;
  logic [TD_W-1:0]         td8_r;
  logic [DOT_W-1:0]        den8_r;
  logic signed [DOT_W-1:0] tn8_r, sn8_r;
  logic [TOL2_W-1:0]       tsq8_r;
  logic signed [CRD_W-1:0] fa8_r [3];
  logic signed [DW-1:0]    d8_r [3];
  // Stage 9: classified item.
  item_t                   item9_r, item9_nxt;

  assign en       = !v_r[9] || q_ready;
  assign in_ready = en;
  assign q_valid  = v_r[9];
  assign q_item   = item9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[8:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [CRD_W-1:0] fs, fe, gs, ge;
        fs = in_data[k*CRD_W +: CRD_W];
        fe = in_data[(3+k)*CRD_W +: CRD_W];
        gs = in_data[(6+k)*CRD_W +: CRD_W];
        ge = in_data[(9+k)*CRD_W +: CRD_W];
        fa1_r[k] <= fs;
        d1_r[k]  <= DW'(fe) - DW'(fs);
        e1_r[k]  <= DW'(ge) - DW'(gs);
        r1_r[k]  <= DW'(gs) - DW'(fs);
      end
      tol1_r <= tol;

      // Component k of a x b is a[k+1]*b[k+2] - a[k+2]*b[k+1].
      cp2_r[0] <= d1_r[1] * e1_r[2];  cn2_r[0] <= d1_r[2] * e1_r[1];
      cp2_r[1] <= d1_r[2] * e1_r[0];  cn2_r[1] <= d1_r[0] * e1_r[2];
      cp2_r[2] <= d1_r[0] * e1_r[1];  cn2_r[2] <= d1_r[1] * e1_r[0];
      ep2_r[0] <= r1_r[1] * e1_r[2];  en2_r[0] <= r1_r[2] * e1_r[1];
      ep2_r[1] <= r1_r[2] * e1_r[0];  en2_r[1] <= r1_r[0] * e1_r[2];
      ep2_r[2] <= r1_r[0] * e1_r[1];  en2_r[2] <= r1_r[1] * e1_r[0];
      dp2_r[0] <= r1_r[1] * d1_r[2];  dn2_r[0] <= r1_r[2] * d1_r[1];
      dp2_r[1] <= r1_r[2] * d1_r[0];  dn2_r[1] <= r1_r[0] * d1_r[2];
      dp2_r[2] <= r1_r[0] * d1_r[1];  dn2_r[2] <= r1_r[1] * d1_r[0];
      fa2_r  <= fa1_r;
      d2_r   <= d1_r;
      r2_r   <= r1_r;
      tol2_r <= tol1_r;

      for (int k = 0; k < 3; k++) begin
        c3_r[k]  <= CW'(cp2_r[k]) - CW'(cn2_r[k]);
        re3_r[k] <= CW'(ep2_r[k]) - CW'(en2_r[k]);
        rd3_r[k] <= CW'(dp2_r[k]) - CW'(dn2_r[k]);
      end
      fa3_r  <= fa2_r;
      d3_r   <= d2_r;
      r3_r   <= r2_r;
      tol3_r <= tol2_r;

      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < C_L; i++) begin
          for (int j = 0; j < C_L; j++) begin
            cc4_pp_r[k][i][j] <= limb(WIDE'(c3_r[k]), i, C_L) *
                                 limb(WIDE'(c3_r[k]), j, C_L);
            tt4_pp_r[k][i][j] <= limb(WIDE'(re3_r[k]), i, C_L) *
                                 limb(WIDE'(c3_r[k]), j, C_L);
            ss4_pp_r[k][i][j] <= limb(WIDE'(rd3_r[k]), i, C_L) *
                                 limb(WIDE'(c3_r[k]), j, C_L);
          end
        end
        for (int i = 0; i < R_L; i++) begin
          for (int j = 0; j < C_L; j++) begin
            rc4_pp_r[k][i][j] <= limb(WIDE'(r3_r[k]), i, R_L) *
                                 limb(WIDE'(c3_r[k]), j, C_L);
          end
        end
      end
      tsq4_r <= TOL2_W'(tol3_r) * TOL2_W'(tol3_r);
      fa4_r  <= fa3_r;
      d4_r   <= d3_r;

      for (int k = 0; k < 3; k++) begin
        logic signed [SQ_W-1:0]  acc_cc, acc_tt, acc_ss;
        logic signed [RCP_W-1:0] acc_rc;
        acc_cc = '0;
        acc_tt = '0;
        acc_ss = '0;
        acc_rc = '0;
        for (int i = 0; i < C_L; i++) begin
          for (int j = 0; j < C_L; j++) begin
            acc_cc = acc_cc + (SQ_W'(cc4_pp_r[k][i][j]) <<< (LB * (i + j)));
            acc_tt = acc_tt + (SQ_W'(tt4_pp_r[k][i][j]) <<< (LB * (i + j)));
            acc_ss = acc_ss + (SQ_W'(ss4_pp_r[k][i][j]) <<< (LB * (i + j)));
          end
        end
        for (int i = 0; i < R_L; i++) begin
          for (int j = 0; j < C_L; j++) begin
            acc_rc = acc_rc + (RCP_W'(rc4_pp_r[k][i][j]) <<< (LB * (i + j)));
          end
        end
        cc5_r[k]  <= acc_cc;
        tt5_r[k]  <= acc_tt;
        ss5_r[k]  <= acc_ss;
        rcp5_r[k] <= acc_rc;
      end
      tsq5_r <= tsq4_r;
      fa5_r  <= fa4_r;
      d5_r   <= d4_r;

      den6_r <= DOT_W'(cc5_r[0]) + DOT_W'(cc5_r[1]) + DOT_W'(cc5_r[2]);
      tn6_r  <= DOT_W'(tt5_r[0]) + DOT_W'(tt5_r[1]) + DOT_W'(tt5_r[2]);
      sn6_r  <= DOT_W'(ss5_r[0]) + DOT_W'(ss5_r[1]) + DOT_W'(ss5_r[2]);
      rc6_r  <= RC_W'(rcp5_r[0]) + RC_W'(rcp5_r[1]) + RC_W'(rcp5_r[2]);
      tsq6_r <= tsq5_r;
      fa6_r  <= fa5_r;
      d6_r   <= d5_r;

      for (int i = 0; i < RC_L; i++) begin
        for (int j = 0; j < RC_L; j++) begin
          rr7_pp_r[i][j] <= limb(WIDE'(rc6_r), i, RC_L) * limb(WIDE'(rc6_r), j, RC_L);
        end
      end
      for (int i = 0; i < TSQ_L; i++) begin
        for (int j = 0; j < DOT_L; j++) begin
          td7_pp_r[i][j] <= limb(WIDE'(tsq6_r), i, TSQ_L) * limb(WIDE'(den6_r), j, DOT_L);
        end
      end
      den7_r <= den6_r;
      tn7_r  <= tn6_r;
      sn7_r  <= sn6_r;
      tsq7_r <= tsq6_r;
      fa7_r  <= fa6_r;
      d7_r   <= d6_r;

      begin : sq_sum
        logic signed [RC2_W-1:0] acc_rr;
        logic signed [TD_W-1:0]  acc_td;
        acc_rr = '0;
        acc_td = '0;
        for (int i = 0; i < RC_L; i++) begin
          for (int j = 0; j < RC_L; j++) begin
            acc_rr = acc_rr + (RC2_W'(rr7_pp_r[i][j]) <<< (LB * (i + j)));
          end
        end
        for (int i = 0; i < TSQ_L; i++) begin
          for (int j = 0; j < DOT_L; j++) begin
            acc_td = acc_td + (TD_W'(td7_pp_r[i][j]) <<< (LB * (i + j)));
          end
        end
        rc2_8_r <= acc_rr;
        td8_r   <= acc_td;
      end
      den8_r <= den7_r;
      tn8_r  <= tn7_r;
      sn8_r  <= sn7_r;
      tsq8_r <= tsq7_r;
      fa8_r  <= fa7_r;
      d8_r   <= d7_r;

      item9_r <= item9_nxt;
    end
  end

  always_comb begin
    logic [LIM_W-1:0] lim;
    logic             t_in, s_in;
    lim  = LIM_W'(tsq8_r) << (2 * FRAC_BITS);
    t_in = !tn8_r[DOT_W-1] && (DOT_W'(tn8_r) <= den8_r);
    s_in = !sn8_r[DOT_W-1] && (DOT_W'(sn8_r) <= den8_r);
    if (den8_r == '0 || den8_r < DOT_W'(lim)) begin
      item9_nxt.rel = REL_PARALLEL;
    end else if (rc2_8_r >= RC2_W'(td8_r)) begin
      item9_nxt.rel = REL_SKEW;
    end else if (t_in) begin
      item9_nxt.rel = s_in ? REL_SEG_SEG : REL_SEG_LINE;
    end else begin
      item9_nxt.rel = REL_LINE;
    end
    for (int k = 0; k < 3; k++) begin
      item9_nxt.fa[k] = fa8_r[k];
      item9_nxt.d[k]  = d8_r[k];
    end
    item9_nxt.tn  = tn8_r;
    item9_nxt.den = den8_r;
  end

endmodule

// ----- hw/rtl/lsi_fifo.sv -----
// ----------------------------------------------------------------------------
// lsi_fifo
// Four-entry queue between the classifying front and the point back end.
// ----------------------------------------------------------------------------
module lsi_fifo
  import lsi_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  item_t wr_item,
  output logic  rd_valid,
  input  logic  rd_ready,
  output item_t rd_item
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  item_t         mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          push, pop;

  assign wr_ready = (cnt_r != (AW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_item  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_item;
  end

endmodule

// ----- hw/rtl/lsi_back.sv -----
// ----------------------------------------------------------------------------
// lsi_back
// Computes the point start1 + round(tn*d/den) per axis through a pipelined
// restoring divider, saturates it and holds the result in the output register.
// ----------------------------------------------------------------------------
module lsi_back
  import lsi_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_ready,
  input  item_t            q_item,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_data
);

  typedef struct packed {
    rel_t                   rel;
    logic [2:0][CRD_W-1:0]  fa;
    logic [2:0]             neg;
    logic [2:0]             ovf;
    logic [DV_W-1:0]        dv;
    logic [2:0][REM_W-1:0]  rem;
    logic [2:0][QB-1:0]     q;
  } div_t;

  logic                    en;
  logic                    b1v_r, b2v_r;
  logic [QB:0]             dvv_r;
  pp_t                     num1_pp_r [3][DOT_L][R_L];
  logic signed [NUM_W-1:0] num2_r [3];
  rel_t                    rel1_r, rel2_r;
  logic [2:0][CRD_W-1:0]   fa1_r, fa2_r;
  logic [DOT_W-1:0]        den1_r, den2_r;
  div_t                    dv_r [QB+1];
  div_t                    dv0_nxt;
  logic                    out_valid_r;
  logic [OUT_W-1:0]        out_data_r, out_data_nxt;

  assign en        = !out_valid_r || out_ready;
  assign q_ready   = en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1v_r       <= 1'b0;
      b2v_r       <= 1'b0;
      dvv_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      b1v_r       <= q_valid;
      b2v_r       <= b1v_r;
      dvv_r       <= {dvv_r[QB-1:0], b2v_r};
      out_valid_r <= dvv_r[QB];
    end
  end

  always_comb begin
    logic [NUM_W-1:0] mag;
    dv0_nxt.rel = rel2_r;
    dv0_nxt.fa  = fa2_r;
    dv0_nxt.dv  = {den2_r, 1'b0};
    dv0_nxt.q   = '0;
    for (int k = 0; k < 3; k++) begin
      dv0_nxt.neg[k] = num2_r[k][NUM_W-1];
      mag = dv0_nxt.neg[k] ? NUM_W'(-num2_r[k]) : NUM_W'(num2_r[k]);
      // Round half away from zero: floor((2|n| + den) / (2 den)).
      dv0_nxt.rem[k] = (REM_W'(mag) << 1) + REM_W'(den2_r);
      dv0_nxt.ovf[k] = dv0_nxt.rem[k] >= (REM_W'(dv0_nxt.dv) << QB);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < DOT_L; i++) begin
          for (int j = 0; j < R_L; j++) begin
            num1_pp_r[k][i][j] <= limb(WIDE'($signed(q_item.tn)), i, DOT_L) *
                                  limb(WIDE'($signed(q_item.d[k])), j, R_L);
          end
        end
      end
      rel1_r   <= q_item.rel;
      fa1_r    <= q_item.fa;
      den1_r   <= q_item.den;

      for (int k = 0; k < 3; k++) begin
        logic signed [NUM_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < DOT_L; i++) begin
          for (int j = 0; j < R_L; j++) begin
            acc = acc + (NUM_W'(num1_pp_r[k][i][j]) <<< (LB * (i + j)));
          end
        end
        num2_r[k] <= acc;
      end
      rel2_r   <= rel1_r;
      fa2_r    <= fa1_r;
      den2_r   <= den1_r;

      dv_r[0]  <= dv0_nxt;
      out_data_r <= out_data_nxt;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar j = 0; j < QB; j++) begin : g_div
    div_t st_nxt;
    always_comb begin
      logic [REM_W-1:0] sub;
      st_nxt = dv_r[j];
      sub    = REM_W'(dv_r[j].dv) << (QB - 1 - j);
      for (int k = 0; k < 3; k++) begin
        if (dv_r[j].rem[k] >= sub) begin
          st_nxt.rem[k]           = dv_r[j].rem[k] - sub;
          st_nxt.q[k][QB - 1 - j] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) dv_r[j+1] <= st_nxt;
    end
  end

  always_comb begin
    logic signed [V_W-1:0]   v;
    logic [2:0][CRD_W-1:0]   hit;
    logic                    sat;
    logic                    keep;
    sat  = 1'b0;
    hit  = '0;
    keep = (dv_r[QB].rel != REL_PARALLEL) && (dv_r[QB].rel != REL_SKEW);
    for (int k = 0; k < 3; k++) begin
      if (dv_r[QB].neg[k]) begin
        v = V_W'($signed(dv_r[QB].fa[k])) - $signed(V_W'(dv_r[QB].q[k]));
      end else begin
        v = V_W'($signed(dv_r[QB].fa[k])) + $signed(V_W'(dv_r[QB].q[k]));
      end
      if ((dv_r[QB].ovf[k] && !dv_r[QB].neg[k]) ||
          (!dv_r[QB].ovf[k] && v > V_W'(32'sh7FFF_FFFF))) begin
        hit[k] = 32'h7FFF_FFFF;
        sat    = 1'b1;
      end else if (dv_r[QB].ovf[k] || v < V_W'(-64'sd2147483648)) begin
        hit[k] = 32'h8000_0000;
        sat    = 1'b1;
      end else begin
        hit[k] = v[CRD_W-1:0];
      end
    end
    if (!keep) begin
      hit = '0;
      sat = 1'b0;
    end
    out_data_nxt = {4'b0, sat, hit[2], hit[1], hit[0], dv_r[QB].rel};
  end

endmodule

// ----- hw/rtl/line_segment_intersect_3d.sv -----
// ----------------------------------------------------------------------------
// line_segment_intersect_3d
// Closest-approach intersection of two 3D lines in signed Q16.16.
// Throughput: one pair per cycle while no stall backs up from the output;
// the front classifier and the back-end divider pipeline each advance on
// their own around a four-entry queue.
// Reset (rst_n low, synchronous) empties all stages and sets the tolerance to 7.
// ----------------------------------------------------------------------------
module line_segment_intersect_3d
  import lsi_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [TOL_W-1:0] cfg_wr_data,   // zero_tolerance
  input  logic             in_tvalid,
  output logic             in_tready,
  // f_start_x/y/z, f_end_x/y/z, g_start_x/y/z, g_end_x/y/z, 32 bits each
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // relation[2:0], hit_x[34:3], hit_y[66:35], hit_z[98:67], saturated[99]
  output logic [OUT_W-1:0] out_tdata
);

  logic [TOL_W-1:0] tol_r;
  logic             f_valid, f_ready, b_valid, b_ready;
  item_t            f_item, b_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_W'(7);
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  lsi_front u_front (
    .clk, .rst_n, .tol(tol_r),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_data(in_tdata),
    .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
  );

  lsi_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item)
  );

  lsi_back u_back (
    .clk, .rst_n,
    .q_valid(b_valid), .q_ready(b_ready), .q_item(b_item),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(out_tdata)
  );

  a_no_point_when_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] == REL_PARALLEL || out_tdata[2:0] == REL_SKEW)
    |-> out_tdata[99:3] == '0)
    else $error("point not zero for parallel or skew result");

  a_rel_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= REL_SKEW)
    else $error("relation code out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_W-1:100] == '0)
    else $error("padding bits not zero");

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the 3D line closest-approach block. A driver
// sends line pairs from a queue, a monitor compares each result with a
// prediction worked out at request accept time in exact 256-bit arithmetic.
// Both stream sides idle at random, and the tolerance is swept over phases.
// ----------------------------------------------------------------------------
module tb;
  import lsi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [255:0] w_t;
  typedef int v3_t[3];

  typedef struct {
    rel_t        rel;
    logic [31:0] x, y, z;
    logic        sat;
  } hit_t;

  localparam int WATCHDOG = 20000;
  localparam int DRAIN    = 80;

  logic             clk = 0;
  logic             rst_n = 0;
  logic             cfg_wr_en = 0;
  logic [TOL_W-1:0] cfg_wr_data = '0;
  logic             in_tvalid = 0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 0;
  logic [OUT_W-1:0] out_tdata;

  logic [IN_W-1:0] pending_req[$];
  hit_t            hit_expected[$];
  logic [IN_W-1:0] cur_req;
  logic [15:0]     tol_mirror = 16'd7;
  bit              idle_on = 1;
  int              errors = 0;
  int              src_gap = 0, snk_gap = 0;
  int              hold_cnt = 0;
  bit              hold_go = 0;
  int              quiet = 0;

  line_segment_intersect_3d u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic void cross3(input w_t a[3], input w_t b[3], output w_t o[3]);
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic w_t dot3(input w_t a[3], input w_t b[3]);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  function automatic hit_t predict_hit(input logic [IN_W-1:0] it, input logic [15:0] tol);
    w_t fa[3], d[3], e[3], r[3], c[3], re[3], rd[3];
    w_t den, tol2, tolw, rc, tn, sn, num, mag, q, v, maxv, minv;
    longint fs, fe, gs, ge;
    hit_t h;
    h.rel = REL_PARALLEL; h.x = 0; h.y = 0; h.z = 0; h.sat = 0;
    maxv = 64'sd2147483647;
    minv = -(w_t'(64'd2147483648));
    for (int k = 0; k < 3; k++) begin
      fs = $signed(it[32*k +: 32]);
      fe = $signed(it[32*(3+k) +: 32]);
      gs = $signed(it[32*(6+k) +: 32]);
      ge = $signed(it[32*(9+k) +: 32]);
      fa[k] = fs; d[k] = fe - fs; e[k] = ge - gs; r[k] = gs - fs;
    end
    cross3(d, e, c);
    den = dot3(c, c);
    tolw = tol;
    tol2 = tolw * tolw;
    if (den == 0 || den < (tol2 <<< (2 * FRAC_BITS))) return h;
    rc = dot3(r, c);
    if (rc * rc >= tol2 * den) begin
      h.rel = REL_SKEW;
      return h;
    end
    cross3(r, e, re);
    cross3(r, d, rd);
    tn = dot3(re, c);
    sn = dot3(rd, c);
    if (tn >= 0 && tn <= den) h.rel = (sn >= 0 && sn <= den) ? REL_SEG_SEG : REL_SEG_LINE;
    else h.rel = REL_LINE;
    for (int k = 0; k < 3; k++) begin
      num = tn * d[k];
      mag = (num < 0) ? -num : num;
      q = (2 * mag + den) / (2 * den);
      if (num < 0) q = -q;
      v = q + fa[k];
      if (v > maxv) begin v = maxv; h.sat = 1; end
      else if (v < minv) begin v = minv; h.sat = 1; end
      case (k)
        0: h.x = v[31:0];
        1: h.y = v[31:0];
        default: h.z = v[31:0];
      endcase
    end
    return h;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  // Driver: a held request only moves on once it has been accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) hit_expected.push_back(predict_hit(cur_req, tol_mirror));
      if (!in_tvalid || in_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_tvalid <= 0;
        end else if (pending_req.size() == 0) begin
          in_tvalid <= 0;
        end else if (idle_on && $urandom_range(0, 15) == 0) begin
          src_gap = $urandom_range(0, 10);
          in_tvalid <= 0;
        end else begin
          cur_req = pending_req.pop_front();
          in_tdata <= cur_req;
          in_tvalid <= 1;
        end
      end
    end
  end

  // Long receiver hold-off, counted here.
  always @(posedge clk) begin
    if (hold_go) hold_cnt <= 400;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
  end

  // Monitor and receiver stalls.
  always @(posedge clk) begin
    hit_t w;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (hit_expected.size() == 0) begin
          errors++;
          $display("UNEXPECTED result %h at %0t", out_tdata, $realtime);
        end else begin
          w = hit_expected.pop_front();
          if (out_tdata[2:0] !== w.rel) report_mismatch("relation", out_tdata[2:0], w.rel);
          if (out_tdata[34:3] !== w.x) report_mismatch("hit_x", out_tdata[34:3], w.x);
          if (out_tdata[66:35] !== w.y) report_mismatch("hit_y", out_tdata[66:35], w.y);
          if (out_tdata[98:67] !== w.z) report_mismatch("hit_z", out_tdata[98:67], w.z);
          if (out_tdata[99] !== w.sat) report_mismatch("saturated", out_tdata[99], w.sat);
        end
      end
      if (hold_go || hold_cnt > 1) begin
        out_tready <= 0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        out_tready <= 0;
      end else if (idle_on && $urandom_range(0, 15) == 0) begin
        snk_gap = $urandom_range(0, 10);
        out_tready <= 0;
      end else begin
        out_tready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else if (pending_req.size() != 0 || in_tvalid || hit_expected.size() != 0) begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic int rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 8191)) - 4096;
      2: return ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
    endcase
  endfunction

  function automatic logic [IN_W-1:0] pack_pair(input v3_t fs, input v3_t fe,
                                               input v3_t gs, input v3_t ge);
    logic [IN_W-1:0] it;
    for (int k = 0; k < 3; k++) begin
      it[32*k +: 32] = fs[k];
      it[32*(3+k) +: 32] = fe[k];
      it[32*(6+k) +: 32] = gs[k];
      it[32*(9+k) +: 32] = ge[k];
    end
    return it;
  endfunction

  // Two lines through a common point, with optional offset and parallel form.
  function automatic logic [IN_W-1:0] crossing_pair(input int kind);
    v3_t p, d, e, fs, fe, gs, ge;
    int a, b, u, w, sc;
    sc = 1 << $urandom_range(0, 14);
    a = $urandom_range(0, 6) - 2; b = $urandom_range(0, 6) - 2;
    u = $urandom_range(0, 6) - 2; w = $urandom_range(0, 6) - 2;
    if (a + b == 0) b = b + 1;
    if (u + w == 0) w = w + 1;
    for (int k = 0; k < 3; k++) begin
      p[k] = $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
      d[k] = ($signed($urandom_range(0, 200)) - 100) * sc;
      e[k] = (kind == 2) ? d[k] * 2 : ($signed($urandom_range(0, 200)) - 100) * sc;
      fs[k] = p[k] - a * d[k]; fe[k] = p[k] + b * d[k];
      gs[k] = p[k] - u * e[k]; ge[k] = p[k] + w * e[k];
      if (kind == 1) gs[k] = gs[k] + $signed($urandom_range(0, 16)) - 8;
      if (kind == 2) gs[k] = gs[k] + $signed($urandom_range(0, 1 << 20));
    end
    return pack_pair(fs, fe, gs, ge);
  endfunction

  function automatic logic [IN_W-1:0] random_pair();
    v3_t fs, fe, gs, ge;
    for (int k = 0; k < 3; k++) begin
      fs[k] = rnd_coord(); fe[k] = rnd_coord(); gs[k] = rnd_coord(); ge[k] = rnd_coord();
    end
    return pack_pair(fs, fe, gs, ge);
  endfunction

  task automatic wait_drained();
    while (pending_req.size() != 0 || in_tvalid || hit_expected.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [15:0] v);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    tol_mirror = v;
    cfg_wr_en <= 0;
    @(posedge clk);
  endtask

  initial begin
    logic [15:0] tols[5];
    v3_t z3, mx, mn, u1;
    int n;
    z3 = '{0, 0, 0}; mx = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
    mn = '{32'h80000000, 32'h80000000, 32'h80000000}; u1 = '{65536, 0, 0};
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: degenerate, extreme, parallel, exact crossings, huge points.
    pending_req.push_back(pack_pair(z3, z3, z3, z3));
    pending_req.push_back(pack_pair(mn, mx, mx, mn));
    pending_req.push_back(pack_pair(mn, mx, mn, '{32'h7fffffff, 32'h80000000, 0}));
    pending_req.push_back(pack_pair(z3, u1, '{0, 65536, 0}, '{65536, 65536, 0}));
    pending_req.push_back(pack_pair(z3, u1, '{32768, -65536, 0}, '{32768, 65536, 0}));
    pending_req.push_back(pack_pair(z3, u1, '{32768, 65536, 0}, '{32768, 131072, 0}));
    pending_req.push_back(pack_pair(z3, u1, '{196608, 65536, 0}, '{196608, 131072, 0}));
    pending_req.push_back(pack_pair(z3, u1, '{32768, -65536, 65536}, '{32768, 65536, 65536}));
    pending_req.push_back(pack_pair(mx, '{32'h7ffffffe, 32'h7fffffff, 32'h7fffffff},
                                    '{0, 32'h7fffffff, 0}, '{0, 32'h7fffffff, 1}));
    pending_req.push_back(pack_pair('{32'h7fff0000, 0, 0}, '{32'h7fff0001, 0, 0},
                                    '{32'h80000000, 5, 0}, '{32'h80000000, 5, 1}));
    pending_req.push_back(pack_pair('{-100, 0, 0}, '{-99, 0, 0}, '{-300, 9, 0}, '{-300, 9, 1}));
    for (int i = 0; i < 10; i++) pending_req.push_back(crossing_pair(i % 3));
    wait_drained();

    tols = '{16'd7, 16'd0, 16'hffff, 16'd1, 16'd0};
    tols[3] = $urandom_range(1, 65535);
    tols[4] = 16'd7;
    for (int ph = 0; ph < 5; ph++) begin
      write_tolerance(tols[ph]);
      if (ph == 4) idle_on = 0;
      for (int i = 0; i < 366; i++) begin
        n = $urandom_range(0, 99);
        if (n < 40) pending_req.push_back(crossing_pair(0));
        else if (n < 55) pending_req.push_back(crossing_pair(1));
        else if (n < 65) pending_req.push_back(crossing_pair(2));
        else pending_req.push_back(random_pair());
      end
      if (ph == 1) begin
        repeat (30) @(posedge clk);
        hold_go <= 1;
        @(posedge clk);
        hold_go <= 0;
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
